// File: rtl/alc_pkg.sv
`timescale 1ns / 1ps

package alc_pkg;

    localparam int KIND_W   = 8;
    localparam int MAC_W    = 48;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;
    localparam int REPLY_W  = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_DISCOVER = 8'd1;
    localparam logic [KIND_W-1:0] KIND_REQUEST  = 8'd3;

    localparam logic [REPLY_W-1:0] REPLY_NONE  = 3'd0;
    localparam logic [REPLY_W-1:0] REPLY_OFFER = 3'd2;
    localparam logic [REPLY_W-1:0] REPLY_ACK   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_GRANTED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_LAST  = 2'd1;

    localparam logic [ADDR_W-1:0] POOL_FIRST_RESET = 32'd3232235876;
    localparam logic [ADDR_W-1:0] POOL_LAST_RESET  = 32'd3232236000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_OWN,
        S_CAND
    } alc_state_t;

    typedef enum logic {
        CMP_OWNER,
        CMP_ADDR
    } cmp_sel_t;

endpackage

// File: rtl/address_lease_allocator.sv
`timescale 1ns / 1ps

// Address lease allocator.
// A request (message_kind, client_mac) is transferred at a rising edge with start high
// and busy low. Exactly one result follows: result_valid is high for one cycle with
// status, reply_kind and granted_address, and the receiver cannot stall it.
// A discover or request first scans the owner table, one entry per cycle, and returns
// the stored address of a matching client. Otherwise pool addresses are tried from
// pool_first upward; each candidate is checked against every stored address, one entry
// per cycle, and the first free one is appended to the table and granted.
// A full table or a spent pool refuses the request. An ignored kind returns its result
// in the next cycle. The scans are paced by the single read port of the lease tables,
// which feeds one shared comparator.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// pool_first (index 0) and pool_last (index 1) and is always ready; the user writes it
// only while the block is idle; the block does not enforce it. Reset empties the lease
// table and restores the default pool; no clearing pass is needed.
module address_lease_allocator
    import alc_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [KIND_W-1:0]     message_kind,
    input  logic [MAC_W-1:0]      client_mac,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [ADDR_W-1:0]     cfg_data,
    output logic                  result_valid,
    output logic [STATUS_W-1:0]   status,
    output logic [REPLY_W-1:0]    reply_kind,
    output logic [ADDR_W-1:0]     granted_address
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    alc_state_t          state_reg, state_next;
    logic [CW-1:0]       total_reg, total_next;
    logic [CW-1:0]       issue_cnt_reg, issue_cnt_next;
    logic                pend_reg, pend_next;
    logic [CW-1:0]       cand_cnt_reg, cand_cnt_next;
    logic [ADDR_W-1:0]   cand_reg, cand_next;
    logic [MAC_W-1:0]    mac_reg, mac_next;
    logic [REPLY_W-1:0]  reply_reg, reply_next;
    logic [ADDR_W-1:0]   pool_first_reg, pool_first_next;
    logic [ADDR_W-1:0]   pool_last_reg, pool_last_next;
    logic                res_valid_reg, res_valid_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [REPLY_W-1:0]  res_kind_reg, res_kind_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;

    logic                wr_en;
    logic [IW-1:0]       rd_addr;
    logic [MAC_W-1:0]    owner_rd;
    logic [ADDR_W-1:0]   addr_rd;
    cmp_sel_t            cmp_sel;
    logic                cmp_eq;
    logic                all_issued;

    alc_ram #(.WIDTH(MAC_W), .DEPTH(TABLE_DEPTH)) u_owner_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (total_reg[IW-1:0]),
        .wr_data (mac_reg),
        .rd_addr (rd_addr),
        .rd_data (owner_rd)
    );

    alc_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH)) u_addr_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (total_reg[IW-1:0]),
        .wr_data (cand_reg),
        .rd_addr (rd_addr),
        .rd_data (addr_rd)
    );

    alc_cmp_unit u_cmp (
        .sel        (cmp_sel),
        .owner_data (owner_rd),
        .addr_data  (addr_rd),
        .mac        (mac_reg),
        .cand       (cand_reg),
        .eq         (cmp_eq)
    );

    assign rd_addr    = issue_cnt_reg[IW-1:0];
    assign all_issued = (issue_cnt_reg >= total_reg);
    assign cmp_sel    = (state_reg == S_CAND) ? CMP_ADDR : CMP_OWNER;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            total_reg      <= '0;
            pend_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
            pool_first_reg <= POOL_FIRST_RESET;
            pool_last_reg  <= POOL_LAST_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            pend_reg       <= pend_next;
            res_valid_reg  <= res_valid_next;
            pool_first_reg <= pool_first_next;
            pool_last_reg  <= pool_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_cnt_reg  <= issue_cnt_next;
        cand_cnt_reg   <= cand_cnt_next;
        cand_reg       <= cand_next;
        mac_reg        <= mac_next;
        reply_reg      <= reply_next;
        res_status_reg <= res_status_next;
        res_kind_reg   <= res_kind_next;
        res_addr_reg   <= res_addr_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        issue_cnt_next  = issue_cnt_reg;
        pend_next       = 1'b0;
        cand_cnt_next   = cand_cnt_reg;
        cand_next       = cand_reg;
        mac_next        = mac_reg;
        reply_next      = reply_reg;
        pool_first_next = pool_first_reg;
        pool_last_next  = pool_last_reg;
        res_valid_next  = 1'b0;
        res_status_next = res_status_reg;
        res_kind_next   = res_kind_reg;
        res_addr_next   = res_addr_reg;
        wr_en           = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POOL_FIRST: pool_first_next = cfg_data;
                CFG_POOL_LAST:  pool_last_next  = cfg_data;
                default:        ;
            endcase
        end

        if ((state_reg == S_OWN || state_reg == S_CAND) && !all_issued)
        begin
            issue_cnt_next = CW'(issue_cnt_reg + 1'b1);
            pend_next      = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mac_next       = client_mac;
                    issue_cnt_next = '0;
                    pend_next      = 1'b0;
                    if (message_kind == KIND_DISCOVER || message_kind == KIND_REQUEST)
                    begin
                        reply_next = (message_kind == KIND_DISCOVER) ? REPLY_OFFER
                                                                     : REPLY_ACK;
                        state_next = S_OWN;
                    end
                    else
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = ST_IGNORED;
                        res_kind_next   = REPLY_NONE;
                        res_addr_next   = '0;
                    end
                end
            end
            S_OWN:
            begin
                if (pend_reg && cmp_eq)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = ST_GRANTED;
                    res_kind_next   = reply_reg;
                    res_addr_next   = addr_rd;
                    state_next      = S_IDLE;
                end
                else if (!pend_reg && all_issued)
                begin
                    issue_cnt_next = '0;
                    pend_next      = 1'b0;
                    if (pool_first_reg > pool_last_reg)
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = ST_EXHAUSTED;
                        res_kind_next   = REPLY_NONE;
                        res_addr_next   = '0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cand_next     = pool_first_reg;
                        cand_cnt_next = '0;
                        state_next    = S_CAND;
                    end
                end
            end
            S_CAND:
            begin
                if (pend_reg && cmp_eq)
                begin
                    issue_cnt_next = '0;
                    pend_next      = 1'b0;
                    if (cand_reg == pool_last_reg || cand_cnt_reg == total_reg)
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = ST_EXHAUSTED;
                        res_kind_next   = REPLY_NONE;
                        res_addr_next   = '0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cand_next     = cand_reg + 1'b1;
                        cand_cnt_next = CW'(cand_cnt_reg + 1'b1);
                    end
                end
                else if (!pend_reg && all_issued)
                begin
                    res_valid_next = 1'b1;
                    res_kind_next  = REPLY_NONE;
                    res_addr_next  = '0;
                    state_next     = S_IDLE;
                    if (total_reg >= DEPTH_C)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en           = 1'b1;
                        total_next      = CW'(total_reg + 1'b1);
                        res_status_next = ST_GRANTED;
                        res_kind_next   = reply_reg;
                        res_addr_next   = cand_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy            = (state_reg != S_IDLE);
    assign cfg_ready       = 1'b1;
    assign result_valid    = res_valid_reg;
    assign status          = res_status_reg;
    assign reply_kind      = res_kind_reg;
    assign granted_address = res_addr_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= DEPTH_C)
        else $error("lease count exceeds table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && message_kind != KIND_DISCOVER && message_kind != KIND_REQUEST)
        |=> (result_valid && status == ST_IGNORED))
        else $error("ignored kind did not report at once");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (state_reg == S_IDLE))
        else $error("result shown while scanning");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != ST_GRANTED) |-> (granted_address == '0
            && reply_kind == REPLY_NONE))
        else $error("refused request carries an address");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == ST_GRANTED) |->
            (reply_kind == REPLY_OFFER || reply_kind == REPLY_ACK))
        else $error("grant without a reply kind");

endmodule

// File: rtl/alc_ram.sv
`timescale 1ns / 1ps

module alc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/alc_cmp_unit.sv
`timescale 1ns / 1ps

module alc_cmp_unit
    import alc_pkg::*;
(
    input  cmp_sel_t          sel,
    input  logic [MAC_W-1:0]  owner_data,
    input  logic [ADDR_W-1:0] addr_data,
    input  logic [MAC_W-1:0]  mac,
    input  logic [ADDR_W-1:0] cand,
    output logic              eq
);

    logic [MAC_W-1:0] op_a;
    logic [MAC_W-1:0] op_b;

    always_comb
    begin
        unique case (sel)
            CMP_OWNER:
            begin
                op_a = owner_data;
                op_b = mac;
            end
            CMP_ADDR:
            begin
                op_a = {{(MAC_W-ADDR_W){1'b0}}, addr_data};
                op_b = {{(MAC_W-ADDR_W){1'b0}}, cand};
            end
            default:
            begin
                op_a = owner_data;
                op_b = mac;
            end
        endcase
    end

    assign eq = (op_a == op_b);

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    import alc_pkg::*;

    localparam int TABLE_DEPTH = 128;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [MAC_W-1:0]  mac;
    } lease_req_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [REPLY_W-1:0]  reply;
        logic [ADDR_W-1:0]   addr;
    } lease_rsp_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [KIND_W-1:0]    message_kind = '0;
    logic [MAC_W-1:0]     client_mac = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data = '0;
    logic                 result_valid;
    logic [STATUS_W-1:0]  status;
    logic [REPLY_W-1:0]   reply_kind;
    logic [ADDR_W-1:0]    granted_address;

    lease_req_t pending_requests[$];
    lease_rsp_t expected_replies[$];
    lease_rsp_t want;

    logic [ADDR_W-1:0] pool_lo = POOL_FIRST_RESET;
    logic [ADDR_W-1:0] pool_hi = POOL_LAST_RESET;
    logic [ADDR_W-1:0] lease_ip [0:TABLE_DEPTH-1];
    logic [MAC_W-1:0]  lease_mac [0:TABLE_DEPTH-1];
    int                leases_held = 0;

    int error_count = 0;
    int idle_left = 0;
    bit steady = 1'b0;

    address_lease_allocator #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .message_kind   (message_kind),
        .client_mac     (client_mac),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .status         (status),
        .reply_kind     (reply_kind),
        .granted_address(granted_address)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic lease_rsp_t grant_lease(lease_req_t req);
        lease_rsp_t         r;
        logic [REPLY_W-1:0] rk;
        logic [ADDR_W:0]    cand;
        int                 k;
        int                 j;
        bit                 found;
        bit                 taken;
        r.status = ST_IGNORED;
        r.reply  = REPLY_NONE;
        r.addr   = '0;
        if (req.kind == KIND_DISCOVER)
            rk = REPLY_OFFER;
        else if (req.kind == KIND_REQUEST)
            rk = REPLY_ACK;
        else
            return r;
        for (k = 0; k < leases_held; k++)
        begin
            if (lease_mac[k] == req.mac)
            begin
                r.status = ST_GRANTED;
                r.reply  = rk;
                r.addr   = lease_ip[k];
                return r;
            end
        end
        // The lowest free address lies within the first leases_held + 1 pool addresses.
        found = 1'b0;
        cand  = {1'b0, pool_lo};
        for (k = 0; k <= leases_held && !found && cand <= {1'b0, pool_hi}; k++)
        begin
            taken = 1'b0;
            for (j = 0; j < leases_held; j++)
            begin
                if (lease_ip[j] == cand[ADDR_W-1:0])
                    taken = 1'b1;
            end
            if (!taken)
                found = 1'b1;
            else
                cand = cand + 1;
        end
        if (!found)
            r.status = ST_EXHAUSTED;
        else if (leases_held >= TABLE_DEPTH)
            r.status = ST_FULL;
        else
        begin
            lease_ip[leases_held]  = cand[ADDR_W-1:0];
            lease_mac[leases_held] = req.mac;
            leases_held++;
            r.status = ST_GRANTED;
            r.reply  = rk;
            r.addr   = cand[ADDR_W-1:0];
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [MAC_W-1:0] fresh_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[MAC_W-1:0];
    endfunction

    function automatic logic [KIND_W-1:0] lease_kind();
        return ($urandom_range(0, 1) != 0) ? KIND_DISCOVER : KIND_REQUEST;
    endfunction

    task automatic flag_error(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic push_request(input logic [KIND_W-1:0] kind, input logic [MAC_W-1:0] mac);
        lease_req_t req;
        req.kind = kind;
        req.mac  = mac;
        pending_requests.push_back(req);
    endtask

    task automatic random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            push_request(KIND_W'($urandom_range(0, 255)), fresh_mac());
        else if (r < 50 && leases_held > 0)
            push_request(lease_kind(), lease_mac[$urandom_range(0, leases_held - 1)]);
        else
            push_request(lease_kind(), fresh_mac());
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || start || busy || expected_replies.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_POOL_FIRST)
            pool_lo = data;
        else if (idx == CFG_POOL_LAST)
            pool_hi = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_pool(input logic [ADDR_W-1:0] first, input logic [ADDR_W-1:0] last);
        write_reg(CFG_POOL_FIRST, first);
        write_reg(CFG_POOL_LAST, last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            message_kind <= '0;
            client_mac   <= '0;
            idle_left = 0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                expected_replies.push_back(grant_lease(pending_requests[0]));
                pending_requests.pop_front();
                idle_left = pick_gap();
            end
            if (idle_left > 0)
            begin
                idle_left = idle_left - 1;
                start <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                start        <= 1'b1;
                message_kind <= pending_requests[0].kind;
                client_mac   <= pending_requests[0].mac;
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_replies.size() == 0)
                flag_error("result transfer with nothing outstanding");
            else
            begin
                want = expected_replies.pop_front();
                if (status !== want.status)
                    flag_error($sformatf("status %0d, expected %0d", status, want.status));
                if (reply_kind !== want.reply)
                    flag_error($sformatf("reply_kind %0d, expected %0d",
                                         reply_kind, want.reply));
                if (granted_address !== want.addr)
                    flag_error($sformatf("granted_address %h, expected %h",
                                         granted_address, want.addr));
            end
        end
    end

    initial
    begin
        #200_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int                round;
        int                n;
        int                i;
        int                sel;
        int                prev_count;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic [ADDR_W:0]   top;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_request(8'd0, '0);
        push_request(8'd255, '1);
        push_request(8'd2, fresh_mac());
        push_request(8'd4, fresh_mac());
        push_request(KIND_DISCOVER, '0);
        push_request(KIND_REQUEST, '0);
        push_request(KIND_DISCOVER, '1);
        push_request(KIND_REQUEST, 48'h5555_5555_5555);
        push_request(KIND_DISCOVER, 48'hAAAA_AAAA_AAAA);
        wait_idle();

        set_pool(32'd0, 32'd1);
        push_request(KIND_DISCOVER, 48'h0000_0000_0001);
        push_request(KIND_REQUEST, 48'h8000_0000_0000);
        push_request(KIND_DISCOVER, 48'h1234_5678_9ABC);
        push_request(KIND_REQUEST, '0);
        wait_idle();

        set_pool(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        push_request(KIND_DISCOVER, 48'h0F0F_0F0F_0F0F);
        push_request(KIND_REQUEST, 48'hF0F0_F0F0_F0F0);
        push_request(KIND_DISCOVER, 48'h00FF_00FF_00FF);
        wait_idle();

        set_pool(32'd10, 32'd5);
        push_request(KIND_DISCOVER, 48'hFF00_FF00_FF00);
        push_request(KIND_REQUEST, 48'h5555_5555_5555);
        wait_idle();
        write_reg(CFG_SPARE_A, $urandom());
        write_reg(CFG_SPARE_B, $urandom());

        for (round = 0; round < 6; round++)
        begin
            steady = (round % 4 == 2);
            sel = $urandom_range(0, 5);
            case (sel)
                0: set_pool(32'd0, 32'hFFFF_FFFF);
                1:
                begin
                    a = $urandom();
                    set_pool(a, a);
                end
                2:
                begin
                    a = $urandom();
                    top = {1'b0, a} + $urandom_range(0, 11);
                    set_pool(a, top[ADDR_W] ? 32'hFFFF_FFFF : top[ADDR_W-1:0]);
                end
                3:
                begin
                    a = $urandom();
                    b = $urandom();
                    if (a == b)
                        b = a ^ 32'd1;
                    set_pool((a > b) ? a : b, (a > b) ? b : a);
                end
                4: set_pool(32'hFFFF_FFFF - $urandom_range(0, 6), 32'hFFFF_FFFF);
                default: set_pool(POOL_FIRST_RESET, POOL_LAST_RESET);
            endcase
            n = $urandom_range(7, 11);
            for (i = 0; i < n; i++)
            begin
                random_request();
                if (i == n / 2 && round % 3 == 1)
                    wait_idle();
            end
            wait_idle();
        end

        steady = 1'b0;
        a = 32'h4000_0000 + ($urandom() & 32'h0FFF_FF00);
        set_pool(a, 32'hFFFF_FFFF);
        while (leases_held < TABLE_DEPTH)
        begin
            prev_count = leases_held;
            if ($urandom_range(0, 19) == 0 && leases_held > 0)
                push_request(lease_kind(), lease_mac[$urandom_range(0, leases_held - 1)]);
            else
                push_request(lease_kind(), fresh_mac());
            wait_idle();
            if (leases_held != prev_count)
                write_reg(CFG_POOL_FIRST, lease_ip[leases_held - 1] + 32'd1);
        end

        for (i = 0; i < 8; i++)
            random_request();
        push_request(KIND_DISCOVER, fresh_mac());
        wait_idle();

        a = lease_ip[$urandom_range(0, TABLE_DEPTH - 1)];
        set_pool(a, a);
        push_request(KIND_REQUEST, fresh_mac());
        push_request(KIND_DISCOVER, lease_mac[$urandom_range(0, TABLE_DEPTH - 1)]);
        wait_idle();

        set_pool(32'd0, 32'hFFFF_FFFF);
        push_request(KIND_DISCOVER, fresh_mac());
        push_request(KIND_REQUEST, lease_mac[TABLE_DEPTH - 1]);
        wait_idle();

        repeat (16) @(posedge clk);
        if (error_count == 0 && expected_replies.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
rtl/alc_pkg.sv
rtl/alc_ram.sv
rtl/alc_cmp_unit.sv
rtl/address_lease_allocator.sv
tb/tb.sv
